>>> rtl/ascp_pkg.sv
// Package: shared types and constants of the ASCII channel frame parser.
package ascp_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam logic [7:0] TIMEOUT_RESET = 8'd11;

  localparam logic [7:0] MARK_START = 8'd60;
  localparam logic [7:0] MARK_SEP   = 8'd61;
  localparam logic [7:0] MARK_END   = 8'd62;
  localparam logic [7:0] DIGIT_LO   = 8'd48;
  localparam logic [7:0] DIGIT_HI   = 8'd57;

  localparam logic [3:0] MAX_COLLECT      = 4'd9;
  localparam logic [3:0] MIN_COLLECT      = 4'd4;
  localparam logic [3:0] MAX_GOOD_COLLECT = 4'd8;
  localparam logic [9:0] CHANNEL_MAX      = 10'd99;
  localparam logic [19:0] VALUE_MAX       = 20'd99999;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [3:0] read_channel;
  } in_item_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_good;
    logic [6:0]  frame_channel;
    logic [16:0] frame_value;
    logic [16:0] read_value;
  } out_item_t;

  // Frame outcome of one item, from the parser to the output pipeline.
  typedef struct packed {
    logic        done;
    logic        good;
    logic [6:0]  channel;
    logic [16:0] value;
  } frame_res_t;

  // Store write request.
  typedef struct packed {
    logic        en;
    logic [6:0]  channel;
    logic [16:0] data;
  } store_wr_t;

endpackage

>>> rtl/ascp_parser.sv
// Frame parser: hunts for the start mark, collects characters, handles ticks.
module ascp_parser import ascp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_item_t   item,
  input  logic [7:0] timeout_ticks,
  output frame_res_t res,
  output store_wr_t  wr
);

  localparam logic [6:0] NUM_CH = 7'(NUM_CHANNELS);

  logic        in_frame_r,   in_frame_nxt;
  logic [3:0]  char_count_r, char_count_nxt;
  logic        in_value_r,   in_value_nxt;
  logic [1:0]  ch_digits_r,  ch_digits_nxt;
  logic [6:0]  ch_accum_r,   ch_accum_nxt;
  logic [16:0] val_accum_r,  val_accum_nxt;
  logic        error_r,      error_nxt;
  logic [7:0]  tick_count_r, tick_count_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [9:0]  ch_n;
  logic [19:0] val_n;
  logic [3:0]  cc_inc;
  logic        good;

  assign is_digit = (item.rx_byte >= DIGIT_LO) && (item.rx_byte <= DIGIT_HI);
  assign digit    = 4'(item.rx_byte - DIGIT_LO);
  assign ch_n     = 10'(ch_accum_r) * 10'd10 + 10'(digit);
  assign val_n    = 20'(val_accum_r) * 20'd10 + 20'(digit);
  assign cc_inc   = char_count_r + 4'd1;
  assign good     = !error_r && in_value_r && (ch_digits_r != 2'd0) &&
                    (cc_inc >= MIN_COLLECT) && (cc_inc <= MAX_GOOD_COLLECT) &&
                    (ch_accum_r < NUM_CH);

  always_comb begin
    in_frame_nxt   = in_frame_r;
    char_count_nxt = char_count_r;
    in_value_nxt   = in_value_r;
    ch_digits_nxt  = ch_digits_r;
    ch_accum_nxt   = ch_accum_r;
    val_accum_nxt  = val_accum_r;
    error_nxt      = error_r;
    tick_count_nxt = tick_count_r;
    res            = '0;
    if (acc) begin
      unique case (item.kind)
        KIND_BYTE: begin
          if (!in_frame_r) begin
            if (item.rx_byte == MARK_START) begin
              in_frame_nxt   = 1'b1;
              char_count_nxt = '0;
              in_value_nxt   = 1'b0;
              ch_digits_nxt  = '0;
              ch_accum_nxt   = '0;
              val_accum_nxt  = '0;
              error_nxt      = 1'b0;
              tick_count_nxt = '0;
            end
          end else begin
            char_count_nxt = cc_inc;
            if (item.rx_byte == MARK_END) begin
              in_frame_nxt = 1'b0;
              res.done     = 1'b1;
              if (good) begin
                res.good    = 1'b1;
                res.channel = ch_accum_r;
                res.value   = val_accum_r;
              end
            end else begin
              if (is_digit && !in_value_r) begin
                if (ch_n > CHANNEL_MAX) error_nxt = 1'b1;
                else ch_accum_nxt = 7'(ch_n);
                if (ch_digits_r != 2'd3) ch_digits_nxt = ch_digits_r + 2'd1;
              end else if (is_digit) begin
                if (val_n > VALUE_MAX) error_nxt = 1'b1;
                else val_accum_nxt = 17'(val_n);
              end else if (item.rx_byte == MARK_SEP && !in_value_r) begin
                in_value_nxt = 1'b1;
              end else begin
                error_nxt = 1'b1;
              end
              // Drop the frame once the length limit is reached.
              if (cc_inc >= MAX_COLLECT) begin
                in_frame_nxt = 1'b0;
                res.done     = 1'b1;
              end
            end
          end
        end
        KIND_TICK: begin
          if (in_frame_r) begin
            if (tick_count_r >= timeout_ticks) begin
              in_frame_nxt = 1'b0;
              res.done     = 1'b1;
            end else begin
              tick_count_nxt = tick_count_r + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign wr.en      = res.good;
  assign wr.channel = res.channel;
  assign wr.data    = res.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      char_count_r <= '0;
      in_value_r   <= 1'b0;
      ch_digits_r  <= '0;
      ch_accum_r   <= '0;
      val_accum_r  <= '0;
      error_r      <= 1'b0;
      tick_count_r <= '0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      char_count_r <= char_count_nxt;
      in_value_r   <= in_value_nxt;
      ch_digits_r  <= ch_digits_nxt;
      ch_accum_r   <= ch_accum_nxt;
      val_accum_r  <= val_accum_nxt;
      error_r      <= error_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

endmodule

>>> rtl/ascp_store.sv
// Channel value store: one-write, one-read synchronous memory with valid bits.
module ascp_store import ascp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  store_wr_t   wr,
  input  logic        rd_en,
  input  logic [3:0]  rd_channel,
  output logic [16:0] rd_data
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [6:0] NUM_CH = 7'(NUM_CHANNELS);

  logic [16:0]             mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [16:0]             mem_q_r;
  logic                    hit_r;
  logic [6:0]              rd_ext;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  assign rd_ext  = 7'(rd_channel);
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr.channel[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Entries never written read as zero; out-of-range channels read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) hit_r <= (rd_ext < NUM_CH) && vld_r[rd_addr];
    end
  end

  assign rd_data = hit_r ? mem_q_r : '0;

endmodule

>>> rtl/ascii_channel_frame_parser.sv
// Top level: ASCII channel frame parser with per-channel value store.
//
// Items (received byte, read request, millisecond tick) are taken one per
// cycle while in_stall is low and each yields exactly one result: the
// parser updates its frame registers in the transfer cycle, the store's
// read port registers the requested value, and the output register holds
// the result until the downstream side takes it. A frame of the form
// <digits=digits> (the value digits may be empty), 5 to 9 characters long,
// naming a channel below NUM_CHANNELS, is written to the store at the
// transfer of its end mark and is visible to any later read request. The
// store is cleared by reset at once through per-entry valid bits, so no
// clearing pass is needed. The timeout register may be written whenever
// cfg_ready is high; write it only while no items are in flight.
module ascii_channel_frame_parser import ascp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       cfg_wr;
  logic [7:0] timeout_ticks_r;

  logic       in_acc;
  logic       s1_adv;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_read_r;
  frame_res_t s1_res_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;

  frame_res_t  pr_res;
  store_wr_t   st_wr;
  logic [16:0] st_rdata;
  logic        rd_en;

  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  // Take a new timeout on each configuration transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_ticks_r <= cfg_data;
    end
  end

  // Stage 1 waits for the store read; it advances whenever the output
  // register is empty or being taken. Stall the input only when stage 1
  // is full and cannot advance.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign rd_en    = in_acc && (in_item.kind == KIND_READ);

  ascp_parser #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .item          (in_item),
    .timeout_ticks (timeout_ticks_r),
    .res           (pr_res),
    .wr            (st_wr)
  );

  ascp_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (st_wr),
    .rd_en      (rd_en),
    .rd_channel (in_item.read_channel),
    .rd_data    (st_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture at input transfer, advance to the output register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r  <= pr_res;
      s1_read_r <= (in_item.kind == KIND_READ);
    end
    if (s1_adv) begin
      out_item_r.frame_done    <= s1_res_r.done;
      out_item_r.frame_good    <= s1_res_r.good;
      out_item_r.frame_channel <= s1_res_r.channel;
      out_item_r.frame_value   <= s1_res_r.value;
      out_item_r.read_value    <= s1_read_r ? st_rdata : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A good frame is always an ended frame.
  a_good_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.frame_done || !out_item_r.frame_good))
    else $error("frame_good without frame_done");

  // A frame result never carries a read value.
  a_done_noread: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_res_r.done) |=> (out_item_r.read_value == '0))
    else $error("read value on a frame result");

  // A stage-1 item that cannot advance is still there next cycle.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("stage 1 lost an item");

  // A store write only comes from a transferred item naming a valid channel.
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> (in_acc && (st_wr.channel < 7'(NUM_CHANNELS))))
    else $error("store write out of range");

endmodule

>>> verif/tb_ascii_channel_frame_parser.sv
// Testbench: ASCII channel frame parser, frame prediction and result checking.
module tb_ascii_channel_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ascp_pkg::*;

  localparam int          N_CH        = NUM_CHANNELS_DEF;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 200000;

  // Predicts one result per accepted item and checks results in order.
  class frame_scoreboard;
    logic [7:0]  timeout;
    bit          in_frame;
    logic [3:0]  n_chars;
    bit          in_value;
    logic [1:0]  ch_digits;
    int unsigned ch_acc;
    int unsigned val_acc;
    bit          bad;
    logic [7:0]  ticks;
    logic [16:0] store [N_CH];
    out_item_t   expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned frames_ended;
    int unsigned frames_stored;

    function new();
      timeout  = TIMEOUT_RESET;
      in_frame = 1'b0;
      n_chars  = '0;
      in_value = 1'b0;
      ch_digits = '0;
      ch_acc   = 0;
      val_acc  = 0;
      bad      = 1'b0;
      ticks    = '0;
      foreach (store[i]) store[i] = '0;
      errors = 0;
      checked = 0;
      frames_ended = 0;
      frames_stored = 0;
    endfunction

    function void set_timeout(logic [7:0] v);
      timeout = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // End the current frame; store it when it is well formed.
    function void close_frame(bit closed, inout out_item_t r);
      r.frame_done = 1'b1;
      if (closed && !bad && in_value && ch_digits != 0 && n_chars >= MIN_COLLECT &&
          n_chars <= MAX_GOOD_COLLECT && ch_acc < N_CH) begin
        store[ch_acc]   = val_acc[16:0];
        r.frame_good    = 1'b1;
        r.frame_channel = ch_acc[6:0];
        r.frame_value   = val_acc[16:0];
      end
      in_frame = 1'b0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   r;
      logic [7:0]  b;
      int unsigned d;
      r = '0;
      b = it.rx_byte;
      case (it.kind)
        KIND_BYTE: begin
          if (!in_frame) begin
            if (b == MARK_START) begin
              in_frame = 1'b1;
              n_chars = '0;
              in_value = 1'b0;
              ch_digits = '0;
              ch_acc = 0;
              val_acc = 0;
              bad = 1'b0;
              ticks = '0;
            end
          end else begin
            n_chars++;
            if (b == MARK_END) begin
              close_frame(1'b1, r);
            end else begin
              if (b >= DIGIT_LO && b <= DIGIT_HI) begin
                d = 32'(b) - 32'(DIGIT_LO);
                if (!in_value) begin
                  if (ch_acc * 10 + d > 32'(CHANNEL_MAX)) bad = 1'b1;
                  else ch_acc = ch_acc * 10 + d;
                  if (ch_digits < 3) ch_digits++;
                end else begin
                  if (val_acc * 10 + d > 32'(VALUE_MAX)) bad = 1'b1;
                  else val_acc = val_acc * 10 + d;
                end
              end else if (b == MARK_SEP && !in_value) begin
                in_value = 1'b1;
              end else begin
                bad = 1'b1;
              end
              if (n_chars >= MAX_COLLECT) close_frame(1'b0, r);
            end
          end
        end
        KIND_READ: begin
          if (it.read_channel < N_CH) r.read_value = store[it.read_channel];
        end
        KIND_TICK: begin
          if (in_frame) begin
            if (ticks >= timeout) close_frame(1'b0, r);
            else ticks++;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function string show(out_item_t r);
      return $sformatf("done=%0d good=%0d ch=%0d value=%0d read=%0d", r.frame_done,
                       r.frame_good, r.frame_channel, r.frame_value, r.read_value);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %s", $time, show(got));
        return;
      end
      want = expected_q.pop_front();
      if (want.frame_done) frames_ended++;
      if (want.frame_good) frames_stored++;
      if (got.frame_done !== want.frame_done || got.frame_good !== want.frame_good ||
          got.frame_channel !== want.frame_channel ||
          got.frame_value !== want.frame_value || got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: mismatch, expected %s, actual %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  frame_scoreboard sb;
  int unsigned     tx_idle_pct = 9;
  int unsigned     rx_idle_pct = 87;
  int unsigned     sent = 0;
  bit              hold_go = 1'b0;

  ascii_channel_frame_parser #(
    .NUM_CHANNELS(N_CH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic in_item_t mk(logic [1:0] k, logic [7:0] b, logic [3:0] c);
    in_item_t it;
    it.kind = k;
    it.rx_byte = b;
    it.read_channel = c;
    return it;
  endfunction

  // Offer one item and return at the edge of its transfer. Valid stays high
  // afterwards so back-to-back items need only one assignment per edge; a
  // random gap drops valid first.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  // Send a character string as received bytes, mixing in ticks and reads.
  task automatic send_text(input string s, input int unsigned mix_pct);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(99) < mix_pct) begin
        if ($urandom_range(1) == 1) send(mk(KIND_TICK, 8'($urandom), 4'($urandom)));
        else send(mk(KIND_READ, 8'($urandom), 4'($urandom)));
      end
      send(mk(KIND_BYTE, s[i], 4'($urandom)));
    end
  endtask

  // Build one frame attempt: well formed, or broken in one way.
  task automatic send_frame();
    string       ch_s;
    string       val_s;
    string       fr;
    int unsigned form;
    int unsigned ndig;
    int unsigned pos;
    form = $urandom_range(0, 14);
    ch_s = $sformatf("%0d", $urandom_range(0, N_CH - 1));
    if ($urandom_range(3) == 0) ch_s = {"0", ch_s};
    ndig = $urandom_range(0, 5);
    if (ndig == 0) val_s = "";
    else val_s = $sformatf("%0d", $urandom_range(0, 10 ** ndig - 1));
    // keep well-formed frames within nine characters
    if (ch_s.len() + val_s.len() > 6) val_s = val_s.substr(0, 5 - ch_s.len());
    case (form)
      7:  ch_s = $sformatf("%0d", $urandom_range(N_CH, 99));       // channel out of range
      8:  ch_s = $sformatf("%0d", $urandom_range(100, 999));       // channel overflows
      9:  val_s = $sformatf("%0d", $urandom_range(100000, 999999)); // value overflows
      10: ch_s = "";                                               // no channel digit
      default: ;
    endcase
    fr = {"<", ch_s, "=", val_s, ">"};
    case (form)
      11: fr = {"<", ch_s, val_s, ">"};                  // separator missing
      12: fr = fr.substr(0, fr.len() - 2);               // end mark missing
      13: begin                                          // one stray character
        pos = $urandom_range(1, fr.len() - 1);
        fr[pos] = 8'($urandom_range(1, 255));
      end
      14: fr = {"<", ch_s, "==", val_s, ">"};            // second separator
      default: ;
    endcase
    send_text(fr, 15);
  endtask

  // Write the timeout register while nothing is in flight.
  task automatic write_timeout(input logic [7:0] v);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_timeout(v);
  endtask

  // One random phase: drain, set the timeout and idling, then stream items.
  task automatic run_phase(input logic [7:0] tmo, input int unsigned tx_pct,
                           input int unsigned rx_pct, input bit hold,
                           input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    in_valid <= 1'b0;
    write_timeout(tmo);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold) hold_go = 1'b1;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) send_frame();
      else if (pick < 80) send(mk(KIND_BYTE, 8'($urandom), 4'($urandom)));
      else if (pick < 88) send(mk(KIND_READ, 8'($urandom), 4'($urandom)));
      else if (pick < 94) send(mk(KIND_TICK, 8'($urandom), 4'($urandom)));
      else send(mk(KIND_UNUSED, 8'($urandom), 4'($urandom)));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested so the
  // block fills up and stalls its input.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Abort a hung run.
  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused kind, tick and bytes while hunting, field extremes,
    // largest value, empty value with a leading-zero channel, read-back.
    send(mk(KIND_UNUSED, 8'hFF, 4'hF));
    send(mk(KIND_TICK, 8'h00, 4'h0));
    send(mk(KIND_READ, 8'hFF, 4'h0));
    send(mk(KIND_BYTE, 8'h00, 4'hF));
    send(mk(KIND_BYTE, 8'hFF, 4'h0));
    send_text("<9=99999>", 0);
    send_text("<015=>", 0);
    send(mk(KIND_READ, 8'h00, 4'd9));
    send(mk(KIND_READ, 8'h00, 4'hF));

    // Random: sender idles little and receiver much, then swapped, then none.
    run_phase(8'd0, 9, 87, 1'b0, 170);
    run_phase(8'd255, 9, 87, 1'b0, 170);
    run_phase(8'd3, 87, 9, 1'b0, 170);
    run_phase(8'($urandom_range(1, 254)), 87, 9, 1'b0, 170);
    run_phase(8'd1, 0, 0, 1'b1, 170);
    run_phase(8'($urandom_range(1, 254)), 0, 0, 1'b0, 170);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items over timeouts 0 to 255 with stalls on both sides; %0d checked",
             sent, sb.checked);
    $display("%0d frame attempts ended, %0d stored in the channel store",
             sb.frames_ended, sb.frames_stored);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
